FILE: rtl/htp_pkg.sv
package htp_pkg;

   localparam int unsigned LIMIT_W = 7;
   localparam int unsigned TOTAL_W = 13;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd70;
   localparam int unsigned PERCENT = 100;

   typedef struct packed {
      logic        mode;
      logic [63:0] key;
      logic [63:0] hash;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [63:0]        stored_value;
      logic               status;
      logic [TOTAL_W-1:0] entry_total;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] hash;
      logic [63:0] key;
      logic [63:0] value;
   } entry_type;

   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_INSERT = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_MAIN,
      ST_GCLR,
      ST_GSCAN,
      ST_GCHK,
      ST_GPUT,
      ST_GSWAP,
      ST_FINAL
   } state_type;

   typedef enum logic [1:0] {
      CL_MAIN,
      CL_MOVE,
      CL_FINAL
   } caller_type;

endpackage

FILE: rtl/hash_table_triangular_probe.sv
// Open-addressing hash table with triangular probing, built around one
// synchronous slot memory (two banks of MAX_CAP slots, one read and one
// write per cycle).
// Input: a transaction is taken when start is high and busy is low; req_data
// carries mode (lookup or insert/update), key, hash and value.
// Result: exactly one per transaction, on rsp_data for a single cycle marked
// by rsp_valid. The receiver cannot stall; the result is simply presented.
// busy drops when the result goes out, so the next transaction can start in
// that cycle. The probe loop visits one slot per cycle, which sets the rate.
// A new key that pushes the load over csr_wr_data percent first grows the
// table: all slots of the new capacity in the other bank are cleared, then
// every old slot is scanned and each live entry is re-probed into the new
// bank, one probe per cycle, and then written. A swap state exchanges the
// banks before the new key is probed and placed.
// After reset the whole slot memory is cleared with busy high. The load
// limit register may be written at any time the block is idle.
module hash_table_triangular_probe #(
   parameter int unsigned INITIAL_CAP = 256,
   parameter int unsigned MAX_CAP     = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  htp_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   output htp_pkg::rsp_type                 rsp_data,
   input  logic                             csr_wr_en,
   input  logic [htp_pkg::LIMIT_W-1:0]      csr_wr_data
);

   localparam int unsigned SW = $clog2(MAX_CAP);
   localparam int unsigned CW = SW + 1;
   localparam int unsigned AW = SW + 1;
   localparam int unsigned LW = CW + 8;
   localparam int unsigned DEPTH = 2 * MAX_CAP;

   htp_pkg::entry_type slot_mem [DEPTH];
   htp_pkg::entry_type rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   htp_pkg::entry_type wr_data;

   htp_pkg::state_type  state_ff, state_in;
   htp_pkg::caller_type caller_ff, caller_in;
   logic [AW-1:0]       cnt_ff, cnt_in;
   logic                p_bank_ff, p_bank_in;
   logic [SW-1:0]       p_idx_ff, p_idx_in;
   logic [CW-1:0]       step_ff, step_in;
   logic [CW-1:0]       p_cap_ff, p_cap_in;
   logic [63:0]         p_key_ff, p_key_in;
   logic [63:0]         p_hash_ff, p_hash_in;
   logic                hit_ff, hit_in;
   logic                space_ff, space_in;
   logic [63:0]         mv_value_ff, mv_value_in;
   htp_pkg::req_type    req_ff, req_in;
   logic                active_ff, active_in;
   logic [CW-1:0]       cap_ff, cap_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [htp_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   htp_pkg::rsp_type    rsp_ff, rsp_in;

   logic [SW-1:0] p_mask;
   logic          pr_match, pr_last, pr_done;
   logic [CW:0]   idx_sum;
   logic [SW-1:0] idx_next;
   logic [CW-1:0] cap_dbl;
   logic [CW-1:0] count_inc;
   logic [LW-1:0] load_lhs, load_rhs;
   logic          need_grow;
   logic          at_max;
   logic          clr_last, gclr_last, scan_last;
   logic          accept;

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   assign accept    = start && (state_ff == htp_pkg::ST_IDLE);
   assign p_mask    = SW'(p_cap_ff - CW'(1));
   assign pr_match  = rd_data_ff.valid && (rd_data_ff.hash == p_hash_ff)
                      && (rd_data_ff.key == p_key_ff);
   assign pr_last   = (step_ff == p_cap_ff - CW'(1));
   assign pr_done   = !rd_data_ff.valid || pr_match || pr_last;
   assign idx_sum   = (CW+1)'(p_idx_ff) + (CW+1)'(step_ff) + (CW+1)'(1);
   assign idx_next  = idx_sum[SW-1:0] & p_mask;
   assign cap_dbl   = cap_ff << 1;
   assign count_inc = count_ff + CW'(1);
   // Capacity is a power of two, so the percentage test becomes a compare
   // of two products with no division.
   assign load_lhs  = LW'(count_inc) * LW'(htp_pkg::PERCENT);
   assign load_rhs  = (LW'(limit_ff) + LW'(1)) * LW'(cap_ff);
   assign need_grow = (load_lhs >= load_rhs) || (count_ff >= cap_ff);
   assign at_max    = (cap_ff >= CW'(MAX_CAP));
   assign clr_last  = (cnt_ff == AW'(DEPTH - 1));
   assign gclr_last = (cnt_ff[SW-1:0] == SW'(cap_dbl - CW'(1)));
   assign scan_last = (cnt_ff[SW-1:0] == SW'(cap_ff - CW'(1)));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         htp_pkg::ST_CLEAR: begin
            if (clr_last) state_in = htp_pkg::ST_IDLE;
         end
         htp_pkg::ST_IDLE: begin
            if (accept) state_in = htp_pkg::ST_PROBE;
         end
         htp_pkg::ST_PROBE: begin
            if (pr_done) begin
               case (caller_ff)
                  htp_pkg::CL_MAIN:  state_in = htp_pkg::ST_MAIN;
                  htp_pkg::CL_MOVE:  state_in = htp_pkg::ST_GPUT;
                  htp_pkg::CL_FINAL: state_in = htp_pkg::ST_FINAL;
                  default:           state_in = htp_pkg::ST_IDLE;
               endcase
            end
         end
         htp_pkg::ST_MAIN: begin
            if (!hit_ff && req_ff.mode == htp_pkg::MODE_INSERT && need_grow && !at_max) begin
               state_in = htp_pkg::ST_GCLR;
            end else begin
               state_in = htp_pkg::ST_IDLE;
            end
         end
         htp_pkg::ST_GCLR: begin
            if (gclr_last) state_in = htp_pkg::ST_GSCAN;
         end
         htp_pkg::ST_GSCAN: state_in = htp_pkg::ST_GCHK;
         htp_pkg::ST_GCHK: begin
            if (rd_data_ff.valid) begin
               state_in = htp_pkg::ST_PROBE;
            end else if (scan_last) begin
               state_in = htp_pkg::ST_GSWAP;
            end else begin
               state_in = htp_pkg::ST_GSCAN;
            end
         end
         htp_pkg::ST_GPUT: begin
            state_in = scan_last ? htp_pkg::ST_GSWAP : htp_pkg::ST_GSCAN;
         end
         htp_pkg::ST_GSWAP: state_in = htp_pkg::ST_PROBE;
         htp_pkg::ST_FINAL: state_in = htp_pkg::ST_IDLE;
         default:           state_in = htp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      caller_in    = caller_ff;
      cnt_in       = cnt_ff;
      p_bank_in    = p_bank_ff;
      p_idx_in     = p_idx_ff;
      step_in      = step_ff;
      p_cap_in     = p_cap_ff;
      p_key_in     = p_key_ff;
      p_hash_in    = p_hash_ff;
      hit_in       = hit_ff;
      space_in     = space_ff;
      mv_value_in  = mv_value_ff;
      req_in       = req_ff;
      active_in    = active_ff;
      cap_in       = cap_ff;
      count_in     = count_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_addr      = {p_bank_ff, p_idx_ff};
      wr_en        = 1'b0;
      wr_addr      = {p_bank_ff, p_idx_ff};
      wr_data      = '{valid: 1'b1, hash: p_hash_ff, key: p_key_ff, value: req_ff.value};

      case (state_ff)
         htp_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = '0;
            cnt_in  = cnt_ff + AW'(1);
         end
         htp_pkg::ST_IDLE: begin
            if (accept) begin
               req_in    = req_data;
               caller_in = htp_pkg::CL_MAIN;
               p_bank_in = active_ff;
               p_cap_in  = cap_ff;
               p_key_in  = req_data.key;
               p_hash_in = req_data.hash;
               p_idx_in  = req_data.hash[SW-1:0] & SW'(cap_ff - CW'(1));
               step_in   = '0;
               rd_addr   = {active_ff, p_idx_in};
            end
         end
         htp_pkg::ST_PROBE: begin
            if (pr_done) begin
               hit_in   = pr_match;
               space_in = !rd_data_ff.valid || pr_match;
            end else begin
               p_idx_in = idx_next;
               step_in  = step_ff + CW'(1);
               rd_addr  = {p_bank_ff, idx_next};
            end
         end
         htp_pkg::ST_MAIN: begin
            rsp_in.found        = hit_ff;
            rsp_in.stored_value = hit_ff ? rd_data_ff.value : 64'd0;
            rsp_in.status       = htp_pkg::STATUS_OK;
            rsp_in.entry_total  = htp_pkg::TOTAL_W'(count_ff);
            rsp_valid_in        = 1'b1;
            if (hit_ff) begin
               wr_en = (req_ff.mode == htp_pkg::MODE_INSERT);
            end else if (req_ff.mode == htp_pkg::MODE_INSERT) begin
               if (need_grow && at_max) begin
                  rsp_in.status = htp_pkg::STATUS_FULL;
               end else if (need_grow) begin
                  rsp_valid_in = 1'b0;
                  cnt_in       = '0;
               end else if (space_ff) begin
                  wr_en              = 1'b1;
                  count_in           = count_inc;
                  rsp_in.entry_total = htp_pkg::TOTAL_W'(count_inc);
               end else begin
                  rsp_in.status = htp_pkg::STATUS_FULL;
               end
            end
         end
         htp_pkg::ST_GCLR: begin
            wr_en   = 1'b1;
            wr_addr = {!active_ff, cnt_ff[SW-1:0]};
            wr_data = '0;
            cnt_in  = gclr_last ? '0 : cnt_ff + AW'(1);
         end
         htp_pkg::ST_GSCAN: begin
            rd_addr = {active_ff, cnt_ff[SW-1:0]};
         end
         htp_pkg::ST_GCHK: begin
            if (rd_data_ff.valid) begin
               caller_in   = htp_pkg::CL_MOVE;
               mv_value_in = rd_data_ff.value;
               p_bank_in   = !active_ff;
               p_cap_in    = cap_dbl;
               p_key_in    = rd_data_ff.key;
               p_hash_in   = rd_data_ff.hash;
               p_idx_in    = rd_data_ff.hash[SW-1:0] & SW'(cap_dbl - CW'(1));
               step_in     = '0;
               rd_addr     = {!active_ff, p_idx_in};
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         htp_pkg::ST_GPUT: begin
            wr_en   = space_ff;
            wr_data = '{valid: 1'b1, hash: p_hash_ff, key: p_key_ff, value: mv_value_ff};
            cnt_in  = cnt_ff + AW'(1);
         end
         htp_pkg::ST_GSWAP: begin
            active_in = !active_ff;
            cap_in    = cap_dbl;
            caller_in = htp_pkg::CL_FINAL;
            p_bank_in = !active_ff;
            p_cap_in  = cap_dbl;
            p_key_in  = req_ff.key;
            p_hash_in = req_ff.hash;
            p_idx_in  = req_ff.hash[SW-1:0] & SW'(cap_dbl - CW'(1));
            step_in   = '0;
            rd_addr   = {!active_ff, p_idx_in};
         end
         htp_pkg::ST_FINAL: begin
            rsp_in.found        = 1'b0;
            rsp_in.stored_value = 64'd0;
            rsp_in.status       = space_ff ? htp_pkg::STATUS_OK : htp_pkg::STATUS_FULL;
            rsp_in.entry_total  = htp_pkg::TOTAL_W'(space_ff ? count_inc : count_ff);
            rsp_valid_in        = 1'b1;
            wr_en               = space_ff;
            if (space_ff) count_in = count_inc;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= htp_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         active_ff    <= 1'b0;
         cap_ff       <= CW'(INITIAL_CAP);
         count_ff     <= '0;
         limit_ff     <= htp_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         active_ff    <= active_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      caller_ff   <= caller_in;
      p_bank_ff   <= p_bank_in;
      p_idx_ff    <= p_idx_in;
      step_ff     <= step_in;
      p_cap_ff    <= p_cap_in;
      p_key_ff    <= p_key_in;
      p_hash_ff   <= p_hash_in;
      hit_ff      <= hit_in;
      space_ff    <= space_in;
      mv_value_ff <= mv_value_in;
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != htp_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/htp_checker.sv
module htp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input htp_pkg::rsp_type            rsp_data
);

   // A result only follows work that kept the block busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without preceding work");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transaction taken but block not busy");

   // Each transaction gives a single result, and two results are never back to back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back results");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == htp_pkg::STATUS_FULL) |-> !rsp_data.found)
      else $error("refused insert reports a hit");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.stored_value == 64'd0))
      else $error("miss with nonzero stored value");

endmodule

bind hash_table_triangular_probe htp_checker u_htp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
